// ===== sv/tmpd_pkg.sv =====
// Package: shared constants and types of the trimmed-mean plug detector.
`default_nettype none

package tmpd_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 10;
  localparam int unsigned ADC_W          = 16;
  localparam int unsigned SAMPLE_W       = 10;
  localparam int unsigned SAMPLE_LSB     = ADC_W - SAMPLE_W;

  // Middle ranks that form the trimmed mean, counted from zero.
  localparam int unsigned TRIM_LO  = 3;
  localparam int unsigned TRIM_CNT = 4;
  localparam int unsigned TRIM_SH  = $clog2(TRIM_CNT);
  localparam int unsigned SUM_W    = SAMPLE_W + TRIM_SH;

  // Configuration registers.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SAMPLE_W;
  localparam logic [CFG_IDX_W-1:0] REG_DETACH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONNECT = 1'd1;
  localparam logic [SAMPLE_W-1:0] DETACH_RST  = 10'd300;
  localparam logic [SAMPLE_W-1:0] CONNECT_RST = 10'd200;

  typedef logic [SAMPLE_W-1:0] sample_t;

  // What one sorting cell shows to its right-hand neighbor.
  typedef struct packed {
    logic    valid;  // cell holds a sample of the current window
    logic    gt;     // cell lies past the insertion point
    sample_t value;
  } node_t;

endpackage

`default_nettype wire

// ===== sv/tmpd_in_if.sv =====
// Interface: input channel carrying one converter word.
`default_nettype none

interface tmpd_in_if;
  logic                            valid;
  logic                            ready;
  logic [tmpd_pkg::ADC_W-1:0]      adc_word;

  modport source (output valid, output adc_word, input ready);
  modport sink   (input valid, input adc_word, output ready);
endinterface

`default_nettype wire

// ===== sv/tmpd_out_if.sv =====
// Interface: output channel carrying the filtered level and the connect flag.
`default_nettype none

interface tmpd_out_if;
  logic                            valid;
  logic                            ready;
  logic [tmpd_pkg::SAMPLE_W-1:0]   filtered_value;
  logic                            cc1_connected;
  logic                            window_done;

  modport source (output valid, output filtered_value, output cc1_connected,
                  output window_done, input ready);
  modport sink   (input valid, input filtered_value, input cc1_connected,
                  input window_done, output ready);
endinterface

`default_nettype wire

// ===== sv/tmpd_cell.sv =====
// Insertion-sort cell: holds one sample of the ordered window.
`default_nettype none

module tmpd_cell (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              insert_i,
  input  wire logic              clear_i,
  input  wire tmpd_pkg::sample_t sample_i,
  input  wire tmpd_pkg::node_t   left_i,
  output tmpd_pkg::node_t        node_o,
  output tmpd_pkg::sample_t      value_d_o
);

  logic              valid_q, valid_d;
  tmpd_pkg::sample_t value_q, value_d;
  logic              gt;

  // The new sample goes in front of an empty cell or a larger value.
  assign gt = !valid_q || (value_q > sample_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    if (insert_i) begin
      if (gt) begin
        value_d = left_i.gt ? left_i.value : sample_i;
      end
      valid_d = clear_i ? 1'b0 : (valid_q | left_i.valid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign node_o    = '{valid: valid_q, gt: gt, value: value_q};
  assign value_d_o = value_d;

  // Occupied cells form a prefix of the chain and stay in ascending order.
  a_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> left_i.valid)
    else $error("occupied cell behind an empty one");
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (left_i.value <= value_q))
    else $error("cell chain out of order");

endmodule

`default_nettype wire

// ===== sv/tmpd_sorter.sv =====
// Chain of insertion-sort cells and the trimmed mean of the middle ranks.
`default_nettype none

module tmpd_sorter #(
  parameter int unsigned WINDOW_LEN = tmpd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              insert_i,
  input  wire logic              clear_i,
  input  wire tmpd_pkg::sample_t sample_i,
  output tmpd_pkg::sample_t      mean_o
);

  tmpd_pkg::node_t   nodes   [WINDOW_LEN+1];
  tmpd_pkg::sample_t values_d[WINDOW_LEN];
  logic [tmpd_pkg::SUM_W-1:0] sum;

  // The head of the chain acts as an always-occupied, never-greater neighbor.
  assign nodes[0] = '{valid: 1'b1, gt: 1'b0, value: '0};

  for (genvar g = 0; g < WINDOW_LEN; g++) begin : g_cell
    tmpd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .insert_i  (insert_i),
      .clear_i   (clear_i),
      .sample_i  (sample_i),
      .left_i    (nodes[g]),
      .node_o    (nodes[g+1]),
      .value_d_o (values_d[g])
    );
  end

  // Ranks are taken after the current sample has been placed.
  always_comb begin
    sum = '0;
    for (int k = 0; k < tmpd_pkg::TRIM_CNT; k++) begin
      sum = sum + {{tmpd_pkg::TRIM_SH{1'b0}}, values_d[tmpd_pkg::TRIM_LO + k]};
    end
  end

  assign mean_o = sum[tmpd_pkg::SUM_W-1:tmpd_pkg::TRIM_SH];

  // The final cell of the chain only fills on the word that closes a window.
  a_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes[WINDOW_LEN].valid |-> (insert_i && clear_i))
    else $error("window overfilled");

endmodule

`default_nettype wire

// ===== sv/trimmed_mean_plug_detect.sv =====
// Top level: trimmed-mean filter of converter words with connector detection.
// A result word appears in the cycle after its input word is accepted.
// Throughput: one word per cycle while the output is drained; the sorting chain places a sample as it is accepted.
// The input is ready whenever the output register is empty or being drained.
// Reset (asynchronous, active low) empties the window, zeroes the filtered
// level and the flag, and loads the thresholds with 300 and 200.
`default_nettype none

module trimmed_mean_plug_detect #(
  parameter int unsigned WINDOW_LEN = tmpd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  tmpd_in_if.sink                               in_i,
  tmpd_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tmpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [tmpd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(WINDOW_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_LEN - 1);

  // Thresholds.
  tmpd_pkg::sample_t detach_q, connect_q;

  // Window position, filtered level, flag and output handshake.
  logic [IDX_W-1:0]  idx_q, idx_d;
  tmpd_pkg::sample_t filt_q, filt_d;
  logic              flag_q, flag_d;
  logic              done_q;
  logic              out_valid_q, out_valid_d;

  logic              accept;
  logic              last;
  tmpd_pkg::sample_t sample;
  tmpd_pkg::sample_t mean;

  // A new word is taken whenever the output register is free or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign sample     = in_i.adc_word[tmpd_pkg::ADC_W-1:tmpd_pkg::SAMPLE_LSB];
  assign last       = (idx_q >= IDX_LAST);

  tmpd_sorter #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_sorter (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .insert_i (accept),
    .clear_i  (last),
    .sample_i (sample),
    .mean_o   (mean)
  );

  // On the word that closes a window the new mean replaces the level; on every
  // accepted word the flag follows the level: above detach clears it, above
  // connect sets it, and it holds when the level is at or below both thresholds.
  always_comb begin
    idx_d       = idx_q;
    filt_d      = filt_q;
    flag_d      = flag_q;
    out_valid_d = out_valid_q && !out_o.ready;
    if (accept) begin
      idx_d       = last ? '0 : idx_q + 1'b1;
      filt_d      = last ? mean : filt_q;
      out_valid_d = 1'b1;
      if (filt_d > detach_q) begin
        flag_d = 1'b0;
      end else if (filt_d > connect_q) begin
        flag_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      filt_q      <= '0;
      flag_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      filt_q      <= filt_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      if (accept) begin
        done_q <= last;
      end
    end
  end

  // Threshold registers; writes to an unknown index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      detach_q  <= tmpd_pkg::DETACH_RST;
      connect_q <= tmpd_pkg::CONNECT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tmpd_pkg::REG_DETACH:  detach_q  <= cfg_data_i;
        tmpd_pkg::REG_CONNECT: connect_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The level and the flag are the state itself, held while the word waits.
  assign out_o.valid          = out_valid_q;
  assign out_o.filtered_value = filt_q;
  assign out_o.cc1_connected  = flag_q;
  assign out_o.window_done    = done_q;

  a_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");
  a_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last) |=> (idx_q == '0) && done_q)
    else $error("window did not close");
  a_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_LAST)
    else $error("window position out of range");

endmodule

`default_nettype wire

// ===== verif/tb_trimmed_mean_plug_detect.sv =====
// Testbench: randomized self-checking test of the trimmed-mean plug detector.
`timescale 1ns / 1ps

module tb_trimmed_mean_plug_detect;

  // The run is stopped as failed if it is still going after this many cycles.
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_LEVEL   = (1 << tmpd_pkg::SAMPLE_W) - 1;

  // One converter word waiting to be sent. When drain_first is set, the word
  // is held back until every reading already owed by the block has arrived.
  typedef struct {
    logic [tmpd_pkg::ADC_W-1:0] word;
    bit                         drain_first;
  } word_item_t;

  // One reading as the block reports it on its output channel.
  typedef struct packed {
    tmpd_pkg::sample_t level;
    logic              connected;
    logic              done;
  } reading_t;

  logic clk_i;
  logic rst_ni;
  logic                            cfg_we_i;
  logic [tmpd_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [tmpd_pkg::CFG_DATA_W-1:0] cfg_data_i;

  tmpd_in_if  in_if ();
  tmpd_out_if out_if ();

  trimmed_mean_plug_detect dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Words that the driver still has to send, and the readings that the block
  // still owes us, oldest first.
  word_item_t pending_words[$];
  reading_t   expected_readings[$];

  // Our own copy of the detector: the sample window, where the next sample
  // goes, the current trimmed mean, the connect flag and both thresholds.
  tmpd_pkg::sample_t level_win [tmpd_pkg::WINDOW_LEN_DEF];
  int unsigned       fill_idx;
  tmpd_pkg::sample_t level_now;
  logic              flag_now;
  tmpd_pkg::sample_t detach_lvl;
  tmpd_pkg::sample_t connect_lvl;

  int unsigned mismatches;
  int unsigned cycle_count;
  int          send_gap;
  int          drain_hold;
  bit          quiet_phase;
  word_item_t  next_item;
  reading_t    got_reading;
  reading_t    want_reading;

  always begin
    #5 clk_i = ~clk_i;
  end

  // Gap length in cycles, used for both the sender and the receiver. Most gaps
  // are zero or short and a few are long. A quiet phase runs with no gaps, so
  // the block also sees long back-to-back stretches.
  function automatic int pick_gap();
    int r;
    if (quiet_phase) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Advances our copy of the detector by one converter word and returns the
  // reading that the block must produce for it. The window is ordered by a
  // plain insertion sort on a copy, then the four middle ranks are averaged.
  function automatic reading_t predict_reading(logic [tmpd_pkg::ADC_W-1:0] word);
    tmpd_pkg::sample_t          ranked [tmpd_pkg::WINDOW_LEN_DEF];
    tmpd_pkg::sample_t          key;
    int                         j;
    logic [tmpd_pkg::SUM_W-1:0] total;
    reading_t                   r;
    r.done = 1'b0;
    level_win[fill_idx] = word[tmpd_pkg::ADC_W-1:tmpd_pkg::SAMPLE_LSB];
    if (fill_idx == tmpd_pkg::WINDOW_LEN_DEF - 1) begin
      fill_idx = 0;
      ranked = level_win;
      for (int i = 1; i < tmpd_pkg::WINDOW_LEN_DEF; i++) begin
        key = ranked[i];
        j = i;
        while (j > 0 && ranked[j-1] > key) begin
          ranked[j] = ranked[j-1];
          j--;
        end
        ranked[j] = key;
      end
      total = '0;
      for (int i = tmpd_pkg::TRIM_LO; i < tmpd_pkg::TRIM_LO + tmpd_pkg::TRIM_CNT; i++) begin
        total += {{tmpd_pkg::TRIM_SH{1'b0}}, ranked[i]};
      end
      level_now = total[tmpd_pkg::SUM_W-1:tmpd_pkg::TRIM_SH];
      r.done = 1'b1;
    end else begin
      fill_idx++;
    end
    // Above detach clears, above connect sets, otherwise the flag holds.
    if (level_now > detach_lvl) begin
      flag_now = 1'b0;
    end else if (level_now > connect_lvl) begin
      flag_now = 1'b1;
    end
    r.level = level_now;
    r.connected = flag_now;
    return r;
  endfunction

  // Driver: presents the pending words one at a time. A word is predicted at
  // the edge where it is accepted, so the expectation is in place well before
  // its reading can come back.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.adc_word <= '0;
      send_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_readings.push_back(predict_reading(in_if.adc_word));
      end
      // The channel slot is free when nothing is offered or it was just taken.
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     (!pending_words[0].drain_first || expected_readings.size() == 0)) begin
          next_item = pending_words.pop_front();
          in_if.valid <= 1'b1;
          in_if.adc_word <= next_item.word;
          send_gap = pick_gap();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes every reading the block offers, compares it field by field
  // with the oldest expectation, and then stalls the output for a while.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      drain_hold = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got_reading.level = out_if.filtered_value;
        got_reading.connected = out_if.cc1_connected;
        got_reading.done = out_if.window_done;
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading: level %0d connected %0b done %0b",
                   $time, got_reading.level, got_reading.connected, got_reading.done);
          mismatches++;
        end else begin
          want_reading = expected_readings.pop_front();
          if (got_reading.level !== want_reading.level) begin
            $display("%0t: filtered_value expected %0d actual %0d",
                     $time, want_reading.level, got_reading.level);
            mismatches++;
          end
          if (got_reading.connected !== want_reading.connected) begin
            $display("%0t: cc1_connected expected %0b actual %0b",
                     $time, want_reading.connected, got_reading.connected);
            mismatches++;
          end
          if (got_reading.done !== want_reading.done) begin
            $display("%0t: window_done expected %0b actual %0b",
                     $time, want_reading.done, got_reading.done);
            mismatches++;
          end
        end
        drain_hold = pick_gap();
      end
      if (drain_hold > 0) begin
        drain_hold--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog for a block that hangs or drops readings.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Waits until every word has been sent and every reading has come back. The
  // queues are looked at on the falling edge, once the driver and the monitor
  // have settled. The block answers in the cycle after acceptance, so the short
  // wait that follows is ample.
  task automatic wait_idle();
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || in_if.valid || expected_readings.size() != 0);
    repeat (3) @(posedge clk_i);
  endtask

  // Writes one threshold register. The block is idle here, so our copy of the
  // register can follow at the edge of the write.
  task automatic write_reg(input logic [tmpd_pkg::CFG_IDX_W-1:0] idx,
                           input tmpd_pkg::sample_t data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      tmpd_pkg::REG_DETACH:  detach_lvl = data;
      tmpd_pkg::REG_CONNECT: connect_lvl = data;
      default: ;
    endcase
  endtask

  // Sets both thresholds to the same random level.
  task automatic tmp_equal_write();
    tmpd_pkg::sample_t lvl;
    lvl = tmpd_pkg::sample_t'($urandom_range(0, MAX_LEVEL));
    write_reg(tmpd_pkg::REG_DETACH, lvl);
    write_reg(tmpd_pkg::REG_CONNECT, lvl);
  endtask

  // Picks a window level that sits on or next to a threshold most of the time,
  // since that is where the flag decisions turn.
  function automatic int pick_level();
    int lvl;
    case ($urandom_range(0, 6))
      0:       lvl = int'(connect_lvl);
      1:       lvl = int'(connect_lvl) + 1;
      2:       lvl = int'(connect_lvl) - 1;
      3:       lvl = int'(detach_lvl);
      4:       lvl = int'(detach_lvl) + 1;
      5:       lvl = int'(detach_lvl) - 1;
      default: lvl = $urandom_range(0, MAX_LEVEL);
    endcase
    if (lvl < 0) begin
      lvl = 0;
    end else if (lvl > MAX_LEVEL) begin
      lvl = MAX_LEVEL;
    end
    return lvl;
  endfunction

  // Queues one full window of words. A shaped window has up to three low and
  // up to three high outliers around a common level, so its trimmed mean is
  // exactly that level; the outliers must be dropped by the trimming. An
  // unshaped window is random words over the whole field. The unused low six
  // bits of every word are random in both cases.
  task automatic queue_window(input int lvl, input bit shaped, input bit hold_first);
    int          vals [tmpd_pkg::WINDOW_LEN_DEF];
    int          n_lo;
    int          n_hi;
    int          pick;
    int          tmp;
    int unsigned noise;
    word_item_t  it;
    n_lo = $urandom_range(0, tmpd_pkg::TRIM_LO);
    n_hi = $urandom_range(0, tmpd_pkg::TRIM_LO);
    for (int k = 0; k < tmpd_pkg::WINDOW_LEN_DEF; k++) begin
      if (k < n_lo) begin
        vals[k] = $urandom_range(0, lvl);
      end else if (k < n_lo + n_hi) begin
        vals[k] = $urandom_range(lvl, MAX_LEVEL);
      end else begin
        vals[k] = lvl;
      end
    end
    for (int k = tmpd_pkg::WINDOW_LEN_DEF - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = vals[k];
      vals[k] = vals[pick];
      vals[pick] = tmp;
    end
    for (int k = 0; k < tmpd_pkg::WINDOW_LEN_DEF; k++) begin
      noise = $urandom;
      if (shaped) begin
        it.word = {vals[k][tmpd_pkg::SAMPLE_W-1:0], noise[tmpd_pkg::SAMPLE_LSB-1:0]};
      end else begin
        it.word = noise[tmpd_pkg::ADC_W-1:0];
      end
      it.drain_first = hold_first && (k == 0);
      pending_words.push_back(it);
    end
  endtask

  // Queues a directed word that needs no drain before it.
  task automatic queue_word(input logic [tmpd_pkg::ADC_W-1:0] word);
    word_item_t it;
    it.word = word;
    it.drain_first = 1'b0;
    pending_words.push_back(it);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    mismatches = 0;
    cycle_count = 0;
    quiet_phase = 1'b0;
    fill_idx = 0;
    level_now = '0;
    flag_now = 1'b0;
    detach_lvl = tmpd_pkg::DETACH_RST;
    connect_lvl = tmpd_pkg::CONNECT_RST;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset thresholds. The first window holds the field
    // extremes, words whose only set bits are the ignored low ones, and
    // alternating patterns; its mean lands far above detach, so the flag stays
    // clear, and during the window the flag holds at level zero.
    queue_word(16'hFFFF);
    queue_word(16'h0000);
    queue_word(16'h003F);
    queue_word(16'hFFC0);
    queue_word(16'h5555);
    queue_word(16'hAAAA);
    queue_word(16'hFFFF);
    queue_word(16'h0000);
    queue_word(16'h8000);
    queue_word(16'h7FFF);
    // The second window is level 250 with three samples at each end of the
    // range; the trimming must drop them all, and 250 sits in the set band.
    queue_word({10'd250, 6'd0});
    queue_word(16'hFFC0);
    queue_word(16'h0000);
    queue_word({10'd250, 6'd21});
    queue_word(16'hFFFF);
    queue_word(16'h003F);
    queue_word({10'd250, 6'd42});
    queue_word(16'hFFC0);
    queue_word(16'h0000);
    queue_word({10'd250, 6'd63});

    // Random phases. Each one changes both thresholds while the block is idle
    // and then sends whole windows. The first three cover the widest set band,
    // an empty set band (connect not below detach), and equal thresholds.
    for (int p = 0; p < 12; p++) begin
      wait_idle();
      case (p)
        0: begin
          write_reg(tmpd_pkg::REG_DETACH, tmpd_pkg::sample_t'(MAX_LEVEL));
          write_reg(tmpd_pkg::REG_CONNECT, '0);
        end
        1: begin
          write_reg(tmpd_pkg::REG_DETACH, '0);
          write_reg(tmpd_pkg::REG_CONNECT, tmpd_pkg::sample_t'(MAX_LEVEL));
        end
        2: begin
          tmp_equal_write();
        end
        default: begin
          write_reg(tmpd_pkg::REG_DETACH,
                    tmpd_pkg::sample_t'($urandom_range(0, MAX_LEVEL)));
          write_reg(tmpd_pkg::REG_CONNECT,
                    tmpd_pkg::sample_t'($urandom_range(0, MAX_LEVEL)));
        end
      endcase
      quiet_phase = (p % 4 == 3);
      for (int w = 0; w < 12; w++) begin
        // Once in the run the sender waits for the block to drain completely.
        queue_window(pick_level(), $urandom_range(0, 4) != 0, p == 5 && w == 6);
      end
    end

    wait_idle();
    if (mismatches == 0 && expected_readings.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
